>>> sv/lsce_pkg.sv
// Shared types, constants and tables for the LS channel estimator / equalizer.
package lsce_pkg;

    localparam int NUM_SC     = 64;
    localparam int SC_W       = 6;
    localparam int MAX_TRAINS = 16;
    localparam int QBITS      = 17;     // quotient magnitude bits, one per divider stage
    localparam int REM_W      = 44;     // |numerator| << 12
    localparam int TRIAL_W    = REM_W + 4;
    localparam int RECIP_W    = 25;
    localparam int RECIP_SH   = 24;

    typedef enum logic [1:0] {
        MODE_EST = 2'd0,
        MODE_AVG = 2'd1,
        MODE_EQ  = 2'd2,
        MODE_UPD = 2'd3
    } mode_t;

    localparam logic [0:0] CFG_BLEND_WEIGHT = 1'b0;
    localparam logic [0:0] CFG_NUM_TRAINS   = 1'b1;

    // Control and side data that rides along with each request.
    typedef struct packed {
        mode_t              mode;
        logic [SC_W-1:0]    sc;
        logic [3:0]         tidx;
        logic signed [15:0] h_re;
        logic signed [15:0] h_im;
        logic signed [19:0] acc_re;
        logic signed [19:0] acc_im;
    } meta_t;

    typedef struct packed {
        logic neg_re;
        logic neg_im;
        logic ovf_re;
        logic ovf_im;
        logic zero;
    } dflag_t;

    typedef struct packed {
        logic signed [15:0] val;
        logic               sat;
    } clip_t;

    // ceil(2^24 / n): exact floor division of any 20-bit value by n = 1..16
    function automatic logic [RECIP_W-1:0] avg_recip(input logic [4:0] n);
        logic [RECIP_W-1:0] r;
        case (n)
            5'd1:    r = 25'd16777216;
            5'd2:    r = 25'd8388608;
            5'd3:    r = 25'd5592406;
            5'd4:    r = 25'd4194304;
            5'd5:    r = 25'd3355444;
            5'd6:    r = 25'd2796203;
            5'd7:    r = 25'd2396746;
            5'd8:    r = 25'd2097152;
            5'd9:    r = 25'd1864136;
            5'd10:   r = 25'd1677722;
            5'd11:   r = 25'd1525202;
            5'd12:   r = 25'd1398102;
            5'd13:   r = 25'd1290556;
            5'd14:   r = 25'd1198373;
            5'd15:   r = 25'd1118482;
            default: r = 25'd1048576;
        endcase
        return r;
    endfunction

    // Sign and clip of a truncated quotient magnitude.
    function automatic clip_t quot_clip(input logic neg, input logic ovf,
                                        input logic [QBITS-1:0] mag);
        clip_t c;
        c.sat = 1'b0;
        if (!neg) begin
            if (ovf || mag > 17'd32767) begin
                c.val = 16'sd32767;
                c.sat = 1'b1;
            end else begin
                c.val = signed'(mag[15:0]);
            end
        end else begin
            if (ovf || mag > 17'd32768) begin
                c.val = -16'sd32768;
                c.sat = 1'b1;
            end else begin
                c.val = signed'(16'(~mag + 17'd1));
            end
        end
        return c;
    endfunction

    function automatic clip_t clip21(input logic signed [20:0] v);
        clip_t c;
        c.sat = 1'b0;
        if (v > 21'sd32767) begin
            c.val = 16'sd32767;
            c.sat = 1'b1;
        end else if (v < -21'sd32768) begin
            c.val = -16'sd32768;
            c.sat = 1'b1;
        end else begin
            c.val = v[15:0];
        end
        return c;
    endfunction

endpackage

>>> sv/ls_channel_estimate_equalize.sv
// LS channel estimator and zero-forcing equalizer, fully pipelined.
// Each request passes through stages 1-3, the divider stages, stages 4-6 and the output register.
// Throughput: one request per cycle while the output is not stalled; a request stalls while an earlier request
// to the same subcarrier that writes the stores is still in the 23-stage pipe.
// Reset: async active low; clears all valids, channel store (by valid bits)
// and config (blend_weight = 1.0, num_trains = 1). Accumulator is not cleared.
module ls_channel_estimate_equalize (
    input  logic                      clk,
    input  logic                      rst_n,
    // config write channel
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [0:0]                cfg_index,
    input  logic [15:0]               cfg_data,
    // input request channel
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                mode,
    input  logic [lsce_pkg::SC_W-1:0] subcarrier,
    input  logic [3:0]                train_index,
    input  logic signed [15:0]        rx_re,
    input  logic signed [15:0]        rx_im,
    input  logic signed [15:0]        ref_re,
    input  logic signed [15:0]        ref_im,
    // result channel
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [lsce_pkg::SC_W-1:0] out_subcarrier,
    output logic signed [15:0]        out_re,
    output logic signed [15:0]        out_im,
    output logic                      zero_divisor,
    output logic                      saturated
);
    import lsce_pkg::*;

    // ------------------------------------------------------------------
    // Config registers
    // ------------------------------------------------------------------
    logic [15:0] blend_reg;
    logic [4:0]  ntrain_reg;
    logic [16:0] alpha;        // blend weight clamped to 1.0
    logic [4:0]  n_eff;        // train count clamped to 1..16

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_reg  <= 16'd32768;
            ntrain_reg <= 5'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_BLEND_WEIGHT: blend_reg  <= cfg_data;
                CFG_NUM_TRAINS:   ntrain_reg <= cfg_data[4:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        alpha = (blend_reg > 16'd32768) ? 17'd32768 : {1'b0, blend_reg};
        if (ntrain_reg == 5'd0)
            n_eff = 5'd1;
        else if (ntrain_reg > 5'(MAX_TRAINS))
            n_eff = 5'(MAX_TRAINS);
        else
            n_eff = ntrain_reg;
    end

    // ------------------------------------------------------------------
    // Pipeline flow: the whole pipe advances unless the output holds a
    // result that the sink is stalling.
    // ------------------------------------------------------------------
    logic adv;
    logic hazard;
    logic in_acc;
    logic out_valid_reg;

    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv || hazard;
    assign in_acc   = in_valid && !in_stall;

    // ------------------------------------------------------------------
    // Stores: channel store (valid bits give the zero reset) and the
    // averaging accumulator (undefined until written).
    // ------------------------------------------------------------------
    logic [31:0]       store_mem [NUM_SC];
    logic [39:0]       acc_mem   [NUM_SC];
    logic [NUM_SC-1:0] store_ok_reg;

    // ------------------------------------------------------------------
    // Stage 1: registered request and store reads
    // ------------------------------------------------------------------
    logic               s1_v_reg;
    mode_t              s1_mode_reg;
    logic [SC_W-1:0]    s1_sc_reg;
    logic [3:0]         s1_tidx_reg;
    logic signed [15:0] s1_rx_re_reg, s1_rx_im_reg, s1_ref_re_reg, s1_ref_im_reg;
    logic [31:0]        s1_h_reg;
    logic               s1_hok_reg;
    logic [39:0]        s1_acc_reg;

    always_ff @(posedge clk)
    begin
        if (adv && in_acc)
        begin
            s1_mode_reg   <= mode_t'(mode);
            s1_sc_reg     <= subcarrier;
            s1_tidx_reg   <= train_index;
            s1_rx_re_reg  <= rx_re;
            s1_rx_im_reg  <= rx_im;
            s1_ref_re_reg <= ref_re;
            s1_ref_im_reg <= ref_im;
            s1_h_reg      <= store_mem[subcarrier];
            s1_acc_reg    <= acc_mem[subcarrier];
            s1_hok_reg    <= store_ok_reg[subcarrier];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: cross products and divisor energy
    // ------------------------------------------------------------------
    logic               s2_v_reg;
    meta_t              s2_m_reg, s2_m_next;
    logic signed [31:0] s2_rr_reg, s2_ii_reg, s2_ir_reg, s2_ri_reg, s2_sr_reg, s2_si_reg;
    logic signed [15:0] b_re, b_im;

    always_comb
    begin
        s2_m_next.mode   = s1_mode_reg;
        s2_m_next.sc     = s1_sc_reg;
        s2_m_next.tidx   = s1_tidx_reg;
        s2_m_next.h_re   = s1_hok_reg ? signed'(s1_h_reg[31:16]) : 16'sd0;
        s2_m_next.h_im   = s1_hok_reg ? signed'(s1_h_reg[15:0])  : 16'sd0;
        s2_m_next.acc_re = signed'(s1_acc_reg[39:20]);
        s2_m_next.acc_im = signed'(s1_acc_reg[19:0]);
        // equalize divides by the stored channel, all else by the reference
        b_re = (s1_mode_reg == MODE_EQ) ? s2_m_next.h_re : s1_ref_re_reg;
        b_im = (s1_mode_reg == MODE_EQ) ? s2_m_next.h_im : s1_ref_im_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_m_reg  <= s2_m_next;
            s2_rr_reg <= s1_rx_re_reg * b_re;
            s2_ii_reg <= s1_rx_im_reg * b_im;
            s2_ir_reg <= s1_rx_im_reg * b_re;
            s2_ri_reg <= s1_rx_re_reg * b_im;
            s2_sr_reg <= b_re * b_re;
            s2_si_reg <= b_im * b_im;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: numerators to sign/magnitude, scaled by 4096; denominator
    // ------------------------------------------------------------------
    logic               s3_v_reg;
    meta_t              s3_m_reg;
    logic [REM_W-1:0]   s3_nre_reg, s3_nim_reg;
    logic               s3_neg_re_reg, s3_neg_im_reg;
    logic [31:0]        s3_den_reg;
    logic signed [32:0] num_re, num_im, mag_re, mag_im;

    always_comb
    begin
        num_re = 33'(s2_rr_reg) + 33'(s2_ii_reg);
        num_im = 33'(s2_ir_reg) - 33'(s2_ri_reg);
        mag_re = num_re[32] ? -num_re : num_re;
        mag_im = num_im[32] ? -num_im : num_im;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_m_reg      <= s2_m_reg;
            s3_nre_reg    <= {mag_re[31:0], 12'd0};
            s3_nim_reg    <= {mag_im[31:0], 12'd0};
            s3_neg_re_reg <= num_re[32];
            s3_neg_im_reg <= num_im[32];
            s3_den_reg    <= 32'(s2_sr_reg) + 32'(s2_si_reg);
        end
    end

    // ------------------------------------------------------------------
    // Divider: restoring, one quotient bit per stage, re and im in
    // parallel against the shared denominator. Stage 0 also flags a
    // quotient of 2^17 or more.
    // ------------------------------------------------------------------
    logic [QBITS-1:0] div_v_reg;
    meta_t            div_m_reg   [QBITS];
    logic [REM_W-1:0] div_rre_reg [QBITS];
    logic [REM_W-1:0] div_rim_reg [QBITS];
    logic [QBITS-1:0] div_qre_reg [QBITS];
    logic [QBITS-1:0] div_qim_reg [QBITS];
    dflag_t           div_f_reg   [QBITS];
    logic [31:0]      div_den_reg [QBITS];

    logic [QBITS-1:0] div_v_in;
    meta_t            div_m_in    [QBITS];
    logic [REM_W-1:0] div_rre_in  [QBITS];
    logic [REM_W-1:0] div_rim_in  [QBITS];
    logic [QBITS-1:0] div_qre_in  [QBITS];
    logic [QBITS-1:0] div_qim_in  [QBITS];
    dflag_t           div_f_in    [QBITS];
    logic [31:0]      div_den_in  [QBITS];

    logic [REM_W-1:0] div_rre_next [QBITS];
    logic [REM_W-1:0] div_rim_next [QBITS];
    logic [QBITS-1:0] div_qre_next [QBITS];
    logic [QBITS-1:0] div_qim_next [QBITS];
    logic [TRIAL_W-1:0] trial      [QBITS];

    always_comb
    begin
        for (int j = 0; j < QBITS; j++)
        begin
            if (j == 0)
            begin
                div_v_in[j]        = s3_v_reg;
                div_m_in[j]        = s3_m_reg;
                div_rre_in[j]      = s3_nre_reg;
                div_rim_in[j]      = s3_nim_reg;
                div_qre_in[j]      = '0;
                div_qim_in[j]      = '0;
                div_den_in[j]      = s3_den_reg;
                div_f_in[j].neg_re = s3_neg_re_reg;
                div_f_in[j].neg_im = s3_neg_im_reg;
                div_f_in[j].ovf_re = 49'(s3_nre_reg) >= (49'(s3_den_reg) << QBITS);
                div_f_in[j].ovf_im = 49'(s3_nim_reg) >= (49'(s3_den_reg) << QBITS);
                div_f_in[j].zero   = (s3_den_reg == 32'd0);
            end
            else
            begin
                div_v_in[j]   = div_v_reg[j-1];
                div_m_in[j]   = div_m_reg[j-1];
                div_rre_in[j] = div_rre_reg[j-1];
                div_rim_in[j] = div_rim_reg[j-1];
                div_qre_in[j] = div_qre_reg[j-1];
                div_qim_in[j] = div_qim_reg[j-1];
                div_den_in[j] = div_den_reg[j-1];
                div_f_in[j]   = div_f_reg[j-1];
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < QBITS; j++)
        begin
            trial[j]        = TRIAL_W'(div_den_in[j]) << (QBITS - 1 - j);
            div_rre_next[j] = div_rre_in[j];
            div_rim_next[j] = div_rim_in[j];
            div_qre_next[j] = div_qre_in[j];
            div_qim_next[j] = div_qim_in[j];
            if (TRIAL_W'(div_rre_in[j]) >= trial[j])
            begin
                div_rre_next[j] = div_rre_in[j] - trial[j][REM_W-1:0];
                div_qre_next[j] = div_qre_in[j] | (QBITS'(1) << (QBITS - 1 - j));
            end
            if (TRIAL_W'(div_rim_in[j]) >= trial[j])
            begin
                div_rim_next[j] = div_rim_in[j] - trial[j][REM_W-1:0];
                div_qim_next[j] = div_qim_in[j] | (QBITS'(1) << (QBITS - 1 - j));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < QBITS; j++)
            begin
                div_m_reg[j]   <= div_m_in[j];
                div_rre_reg[j] <= div_rre_next[j];
                div_rim_reg[j] <= div_rim_next[j];
                div_qre_reg[j] <= div_qre_next[j];
                div_qim_reg[j] <= div_qim_next[j];
                div_den_reg[j] <= div_den_in[j];
                div_f_reg[j]   <= div_f_in[j];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: sign, clip, zero-divisor override
    // ------------------------------------------------------------------
    logic               s4_v_reg;
    meta_t              s4_m_reg;
    logic signed [15:0] s4_q_re_reg, s4_q_im_reg;
    logic               s4_zero_reg, s4_sat_reg;
    clip_t              cq_re, cq_im;
    dflag_t             fl;

    always_comb
    begin
        fl    = div_f_reg[QBITS-1];
        cq_re = quot_clip(fl.neg_re, fl.ovf_re, div_qre_reg[QBITS-1]);
        cq_im = quot_clip(fl.neg_im, fl.ovf_im, div_qim_reg[QBITS-1]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_m_reg    <= div_m_reg[QBITS-1];
            s4_zero_reg <= fl.zero;
            s4_q_re_reg <= fl.zero ? 16'sd0 : cq_re.val;
            s4_q_im_reg <= fl.zero ? 16'sd0 : cq_im.val;
            s4_sat_reg  <= !fl.zero && (cq_re.sat || cq_im.sat);
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: accumulator sum (20-bit wrap) and its magnitude
    // ------------------------------------------------------------------
    logic               s5_v_reg;
    meta_t              s5_m_reg;
    logic signed [15:0] s5_q_re_reg, s5_q_im_reg;
    logic               s5_zero_reg, s5_sat_reg, s5_last_reg;
    logic signed [19:0] s5_s_re_reg, s5_s_im_reg;
    logic [19:0]        s5_mag_re_reg, s5_mag_im_reg;
    logic signed [19:0] sum_re, sum_im;

    always_comb
    begin
        sum_re = 20'(s4_q_re_reg);
        sum_im = 20'(s4_q_im_reg);
        if (s4_m_reg.tidx != 4'd0)
        begin
            sum_re = sum_re + s4_m_reg.acc_re;
            sum_im = sum_im + s4_m_reg.acc_im;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_m_reg      <= s4_m_reg;
            s5_q_re_reg   <= s4_q_re_reg;
            s5_q_im_reg   <= s4_q_im_reg;
            s5_zero_reg   <= s4_zero_reg;
            s5_sat_reg    <= s4_sat_reg;
            s5_s_re_reg   <= sum_re;
            s5_s_im_reg   <= sum_im;
            s5_mag_re_reg <= sum_re[19] ? 20'(-sum_re) : 20'(sum_re);
            s5_mag_im_reg <= sum_im[19] ? 20'(-sum_im) : 20'(sum_im);
            s5_last_reg   <= ({1'b0, s4_m_reg.tidx} == n_eff - 5'd1);
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: products for the mean (reciprocal) and for the blend
    // ------------------------------------------------------------------
    logic               s6_v_reg;
    meta_t              s6_m_reg;
    logic signed [15:0] s6_q_re_reg, s6_q_im_reg;
    logic               s6_zero_reg, s6_sat_reg, s6_last_reg;
    logic signed [19:0] s6_s_re_reg, s6_s_im_reg;
    logic [44:0]        s6_avg_re_reg, s6_avg_im_reg;
    logic signed [33:0] s6_bq_re_reg, s6_bq_im_reg, s6_bh_re_reg, s6_bh_im_reg;
    logic signed [17:0] w_new, w_old;
    logic [RECIP_W-1:0] recip;

    always_comb
    begin
        w_new = signed'({1'b0, alpha});
        w_old = signed'({1'b0, 17'd32768 - alpha});
        recip = avg_recip(n_eff);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s6_m_reg      <= s5_m_reg;
            s6_q_re_reg   <= s5_q_re_reg;
            s6_q_im_reg   <= s5_q_im_reg;
            s6_zero_reg   <= s5_zero_reg;
            s6_sat_reg    <= s5_sat_reg;
            s6_last_reg   <= s5_last_reg;
            s6_s_re_reg   <= s5_s_re_reg;
            s6_s_im_reg   <= s5_s_im_reg;
            s6_avg_re_reg <= 45'(s5_mag_re_reg) * 45'(recip);
            s6_avg_im_reg <= 45'(s5_mag_im_reg) * 45'(recip);
            s6_bq_re_reg  <= w_new * s5_q_re_reg;
            s6_bq_im_reg  <= w_new * s5_q_im_reg;
            s6_bh_re_reg  <= w_old * s5_m_reg.h_re;
            s6_bh_im_reg  <= w_old * s5_m_reg.h_im;
        end
    end

    // ------------------------------------------------------------------
    // Finish: per-mode result, store writes, output register
    // ------------------------------------------------------------------
    logic signed [15:0] res_re, res_im;
    logic               res_sat;
    logic               wr_store, wr_acc;
    logic signed [20:0] avg_re, avg_im;
    logic signed [34:0] bl_re, bl_im;
    clip_t              ca_re, ca_im;
    logic [SC_W-1:0]    out_sc_reg;
    logic signed [15:0] out_re_reg, out_im_reg;
    logic               out_zero_reg, out_sat_reg;

    always_comb
    begin
        avg_re = s6_s_re_reg[19] ? -signed'({1'b0, s6_avg_re_reg[43:24]})
                                 :  signed'({1'b0, s6_avg_re_reg[43:24]});
        avg_im = s6_s_im_reg[19] ? -signed'({1'b0, s6_avg_im_reg[43:24]})
                                 :  signed'({1'b0, s6_avg_im_reg[43:24]});
        ca_re  = clip21(avg_re);
        ca_im  = clip21(avg_im);
        bl_re  = 35'(s6_bq_re_reg) + 35'(s6_bh_re_reg) + 35'sd16384;
        bl_im  = 35'(s6_bq_im_reg) + 35'(s6_bh_im_reg) + 35'sd16384;

        res_re   = s6_q_re_reg;
        res_im   = s6_q_im_reg;
        res_sat  = s6_sat_reg;
        wr_store = 1'b0;
        wr_acc   = 1'b0;
        unique case (s6_m_reg.mode)
            MODE_EST:
            begin
                wr_store = 1'b1;
            end
            MODE_AVG:
            begin
                wr_acc = 1'b1;
                if (s6_last_reg)
                begin
                    res_re   = ca_re.val;
                    res_im   = ca_im.val;
                    res_sat  = s6_sat_reg || ca_re.sat || ca_im.sat;
                    wr_store = 1'b1;
                end
            end
            MODE_UPD:
            begin
                // floor((a*q + (1-a)*h + 0.5) / 2^15)
                res_re   = bl_re[30:15];
                res_im   = bl_im[30:15];
                wr_store = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv && s6_v_reg)
        begin
            out_sc_reg   <= s6_m_reg.sc;
            out_re_reg   <= res_re;
            out_im_reg   <= res_im;
            out_zero_reg <= s6_zero_reg;
            out_sat_reg  <= res_sat;
            if (wr_store)
                store_mem[s6_m_reg.sc] <= {res_re, res_im};
            if (wr_acc)
                acc_mem[s6_m_reg.sc] <= {s6_s_re_reg, s6_s_im_reg};
        end
    end

    // ------------------------------------------------------------------
    // Valid chain and store valid bits
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            s3_v_reg      <= 1'b0;
            div_v_reg     <= '0;
            s4_v_reg      <= 1'b0;
            s5_v_reg      <= 1'b0;
            s6_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            store_ok_reg  <= '0;
        end
        else if (adv)
        begin
            s1_v_reg      <= in_acc;
            s2_v_reg      <= s1_v_reg;
            s3_v_reg      <= s2_v_reg;
            div_v_reg     <= div_v_in;
            s4_v_reg      <= div_v_reg[QBITS-1];
            s5_v_reg      <= s4_v_reg;
            s6_v_reg      <= s5_v_reg;
            out_valid_reg <= s6_v_reg;
            if (s6_v_reg && wr_store)
                store_ok_reg[s6_m_reg.sc] <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Read-after-write interlock: hold a request while any request in
    // flight to the same subcarrier will still write a store.
    // ------------------------------------------------------------------
    always_comb
    begin
        hazard = 1'b0;
        if (s1_v_reg && s1_mode_reg != MODE_EQ && s1_sc_reg == subcarrier)
            hazard = 1'b1;
        if (s2_v_reg && s2_m_reg.mode != MODE_EQ && s2_m_reg.sc == subcarrier)
            hazard = 1'b1;
        if (s3_v_reg && s3_m_reg.mode != MODE_EQ && s3_m_reg.sc == subcarrier)
            hazard = 1'b1;
        for (int j = 0; j < QBITS; j++)
        begin
            if (div_v_reg[j] && div_m_reg[j].mode != MODE_EQ && div_m_reg[j].sc == subcarrier)
                hazard = 1'b1;
        end
        if (s4_v_reg && s4_m_reg.mode != MODE_EQ && s4_m_reg.sc == subcarrier)
            hazard = 1'b1;
        if (s5_v_reg && s5_m_reg.mode != MODE_EQ && s5_m_reg.sc == subcarrier)
            hazard = 1'b1;
        if (s6_v_reg && s6_m_reg.mode != MODE_EQ && s6_m_reg.sc == subcarrier)
            hazard = 1'b1;
    end

    assign out_valid      = out_valid_reg;
    assign out_subcarrier = out_sc_reg;
    assign out_re         = out_re_reg;
    assign out_im         = out_im_reg;
    assign zero_divisor   = out_zero_reg;
    assign saturated      = out_sat_reg;

endmodule
